>>> rtl/nps_pkg.sv
`timescale 1ns / 1ps

package nps_pkg;

    // Width of the start value and of the prime; the design holds for 4 to 32.
    localparam int unsigned VALUE_BITS = 12;

    // Trial divisors stop just above sqrt(2**VALUE_BITS), so half the width plus one
    // bit holds every divisor that is tried.
    localparam int unsigned DIV_BITS = VALUE_BITS / 2 + 1;

    // The running square of the divisor overshoots the candidate by at most
    // 2*sqrt(c)+1, which stays below 2**(VALUE_BITS+1).
    localparam int unsigned SQ_BITS = VALUE_BITS + 1;

    // Bit counter of the serial remainder unit.
    localparam int unsigned CNT_BITS = $clog2(VALUE_BITS + 1);

    // Distance from 2**bits down to the largest prime below it.
    function automatic int unsigned prime_offset(input int unsigned bits);
        int unsigned k;
        begin
            unique case (bits)
                4:       k = 3;
                5:       k = 1;
                6:       k = 3;
                7:       k = 1;
                8:       k = 5;
                9:       k = 3;
                10:      k = 3;
                11:      k = 9;
                12:      k = 3;
                13:      k = 1;
                14:      k = 3;
                15:      k = 19;
                16:      k = 15;
                17:      k = 1;
                18:      k = 5;
                19:      k = 1;
                20:      k = 3;
                21:      k = 9;
                22:      k = 3;
                23:      k = 15;
                24:      k = 3;
                25:      k = 39;
                26:      k = 5;
                27:      k = 39;
                28:      k = 57;
                29:      k = 3;
                30:      k = 35;
                31:      k = 1;
                32:      k = 5;
                default: k = 1;
            endcase
            return k;
        end
    endfunction

    localparam logic [63:0] LARGEST_PRIME =
        (64'd1 << VALUE_BITS) - 64'(prime_offset(VALUE_BITS));

    // Largest start value whose next prime still fits in the field.
    localparam logic [VALUE_BITS-1:0] ACCEPT_LIMIT = VALUE_BITS'(LARGEST_PRIME - 64'd1);

    typedef struct packed {
        logic start;
    } t_rem_ctl;

    typedef struct packed {
        logic done;
        logic zero;
    } t_rem_stat;

endpackage

>>> rtl/nps_serial_rem.sv
`timescale 1ns / 1ps

// Restoring remainder, one dividend bit per cycle, most significant bit first.
module nps_serial_rem (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  nps_pkg::t_rem_ctl                  i_ctl,
    input  logic [nps_pkg::VALUE_BITS-1:0]     i_dividend,
    input  logic [nps_pkg::DIV_BITS-1:0]       i_divisor,
    output nps_pkg::t_rem_stat                 o_stat
);

    logic [nps_pkg::VALUE_BITS-1:0] r_shift, n_shift;
    logic [nps_pkg::DIV_BITS-1:0]   r_rem, n_rem;
    logic [nps_pkg::DIV_BITS-1:0]   r_divisor, n_divisor;
    logic [nps_pkg::CNT_BITS-1:0]   r_count, n_count;
    logic                           r_busy, n_busy;
    logic                           r_done, n_done;
    logic [nps_pkg::DIV_BITS:0]     w_trial;

    // The partial remainder stays below the divisor, so one compare and
    // subtract per bit keeps it reduced.
    always_comb begin
        w_trial   = {r_rem, r_shift[nps_pkg::VALUE_BITS-1]};
        n_shift   = r_shift;
        n_rem     = r_rem;
        n_divisor = r_divisor;
        n_count   = r_count;
        n_busy    = r_busy;
        n_done    = 1'b0;
        if (i_ctl.start) begin
            n_shift   = i_dividend;
            n_rem     = '0;
            n_divisor = i_divisor;
            n_count   = '0;
            n_busy    = 1'b1;
        end else if (r_busy) begin
            if (w_trial >= {1'b0, r_divisor}) begin
                w_trial = w_trial - {1'b0, r_divisor};
            end
            n_rem   = w_trial[nps_pkg::DIV_BITS-1:0];
            n_shift = {r_shift[nps_pkg::VALUE_BITS-2:0], 1'b0};
            n_count = r_count + nps_pkg::CNT_BITS'(1);
            if (r_count == nps_pkg::CNT_BITS'(nps_pkg::VALUE_BITS - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_shift   <= n_shift;
        r_rem     <= n_rem;
        r_divisor <= n_divisor;
        r_count   <= n_count;
    end

    assign o_stat.done = r_done;
    assign o_stat.zero = (r_rem == '0);

endmodule

>>> rtl/next_prime_search.sv
`timescale 1ns / 1ps

// Channel | Direction | Handshake                 | Payload
// --------+-----------+---------------------------+------------------------------
// in      | input     | i_in_valid / o_in_stall   | i_start_value
// out     | output    | o_out_valid / i_out_stall | o_next_prime, o_range_error
//
// One start value is searched at a time. An out-of-range value skips the search:
// S_IDLE sends it straight to S_FINISH, and from there it enters the output register.
// Otherwise each trial division is a square test in S_CHECK and then a pass through the
// bit-serial remainder unit in S_DIVIDE, until a candidate passes the square test.
// Reset (i_rst_n low at a clock edge) returns the sequencer to idle and empties
// the output register. A new value is taken while a result waits in the output
// register; a finished search holds until that register frees up.
module next_prime_search (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [nps_pkg::VALUE_BITS-1:0]     i_start_value,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [nps_pkg::VALUE_BITS-1:0]     o_next_prime,
    output logic                               o_range_error
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_CHECK  = 4'b0010,
        S_DIVIDE = 4'b0100,
        S_FINISH = 4'b1000
    } t_state;

    t_state                          r_state, n_state;
    logic [nps_pkg::VALUE_BITS-1:0]  r_cand, n_cand;
    logic [nps_pkg::DIV_BITS-1:0]    r_div, n_div;
    logic [nps_pkg::SQ_BITS-1:0]     r_square, n_square;
    logic [nps_pkg::VALUE_BITS-1:0]  r_res_prime, n_res_prime;
    logic                            r_res_err, n_res_err;
    logic                            r_out_valid, n_out_valid;
    logic [nps_pkg::VALUE_BITS-1:0]  r_out_prime, n_out_prime;
    logic                            r_out_err, n_out_err;
    nps_pkg::t_rem_ctl               w_rem_ctl;
    nps_pkg::t_rem_stat              w_rem_stat;
    logic                            w_in_xfer;
    logic                            w_load_out;

    assign w_in_xfer  = i_in_valid && (r_state == S_IDLE);
    assign w_load_out = (r_state == S_FINISH) && (!r_out_valid || !i_out_stall);

    always_comb begin
        n_state          = r_state;
        n_cand           = r_cand;
        n_div            = r_div;
        n_square         = r_square;
        n_res_prime      = r_res_prime;
        n_res_err        = r_res_err;
        w_rem_ctl.start  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_xfer) begin
                    n_div    = nps_pkg::DIV_BITS'(2);
                    n_square = nps_pkg::SQ_BITS'(4);
                    // First candidate is n + 1, moved up to odd unless it is two.
                    if (i_start_value[0] && (i_start_value != nps_pkg::VALUE_BITS'(1))) begin
                        n_cand = i_start_value + nps_pkg::VALUE_BITS'(2);
                    end else begin
                        n_cand = i_start_value + nps_pkg::VALUE_BITS'(1);
                    end
                    if ((i_start_value == '0) || (i_start_value > nps_pkg::ACCEPT_LIMIT)) begin
                        n_res_prime = '0;
                        n_res_err   = 1'b1;
                        n_state     = S_FINISH;
                    end else begin
                        n_state = S_CHECK;
                    end
                end
            end
            S_CHECK: begin
                // No divisor up to the square root divides the candidate.
                if (r_square > {1'b0, r_cand}) begin
                    n_res_prime = r_cand;
                    n_res_err   = 1'b0;
                    n_state     = S_FINISH;
                end else begin
                    w_rem_ctl.start = 1'b1;
                    n_state         = S_DIVIDE;
                end
            end
            S_DIVIDE: begin
                if (w_rem_stat.done) begin
                    if (w_rem_stat.zero) begin
                        n_cand   = r_cand + nps_pkg::VALUE_BITS'(2);
                        n_div    = nps_pkg::DIV_BITS'(2);
                        n_square = nps_pkg::SQ_BITS'(4);
                    end else begin
                        // (d + 1)^2 = d^2 + 2d + 1
                        n_div    = r_div + nps_pkg::DIV_BITS'(1);
                        n_square = r_square + nps_pkg::SQ_BITS'({r_div, 1'b0})
                                 + nps_pkg::SQ_BITS'(1);
                    end
                    n_state = S_CHECK;
                end
            end
            S_FINISH: begin
                if (w_load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        n_out_prime = r_out_prime;
        n_out_err   = r_out_err;
        if (w_load_out) begin
            n_out_valid = 1'b1;
            n_out_prime = r_res_prime;
            n_out_err   = r_res_err;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_cand      <= n_cand;
        r_div       <= n_div;
        r_square    <= n_square;
        r_res_prime <= n_res_prime;
        r_res_err   <= n_res_err;
        r_out_prime <= n_out_prime;
        r_out_err   <= n_out_err;
    end

    nps_serial_rem u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_rem_ctl),
        .i_dividend (r_cand),
        .i_divisor  (r_div),
        .o_stat     (w_rem_stat)
    );

    assign o_in_stall    = (r_state != S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_next_prime  = r_out_prime;
    assign o_range_error = r_out_err;

endmodule

>>> bench/next_prime_search_tb.sv
`timescale 1ns / 1ps

module next_prime_search_tb;

    localparam int unsigned VB = nps_pkg::VALUE_BITS;
    localparam int unsigned DIRECTED_COUNT = 24;
    localparam int unsigned RANDOM_COUNT = 76;
    // Each item is allowed four times a generous search bound plus the input gap and
    // output stall that its transfer may wait out, with room for eight more items.
    localparam longint unsigned CYCLE_LIMIT =
        64'd4 * 64'(DIRECTED_COUNT + RANDOM_COUNT + 8) * 64'd20040 + 64'd10000;

    typedef struct packed {
        logic [VB-1:0] prime;
        logic          range_err;
    } t_prime_result;

    class t_prime_checker;
        t_prime_result   expected_primes[$];
        longint unsigned accept_max;
        int              mismatches;
        int              checked;
        int              range_errs;

        static function bit is_prime(longint unsigned c);
            longint unsigned d;
            if (c < 2) return 1'b0;
            for (d = 2; d * d <= c; d++) begin
                if (c % d == 0) return 1'b0;
            end
            return 1'b1;
        endfunction

        function new();
            longint unsigned p;
            p = (64'd1 << VB) - 64'd1;
            while (p >= 2 && !is_prime(p)) p--;
            // The next prime of any accepted start value must fit in the field.
            accept_max = (p >= 2) ? p - 1 : 0;
            mismatches = 0;
            checked = 0;
            range_errs = 0;
        endfunction

        function t_prime_result smallest_prime_above(logic [VB-1:0] n);
            t_prime_result   r;
            longint unsigned c;
            r.prime = '0;
            r.range_err = 1'b1;
            if (n == 0 || longint'(n) > accept_max) return r;
            c = longint'(n) + 1;
            if (c > 2 && (c & 1) == 0) c++;
            while (!is_prime(c)) c += 2;
            r.prime = VB'(c);
            r.range_err = 1'b0;
            return r;
        endfunction

        function void note_start(logic [VB-1:0] n);
            expected_primes.push_back(smallest_prime_above(n));
        endfunction

        function void check_result(logic [VB-1:0] prime, logic range_err);
            t_prime_result want;
            if (expected_primes.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result: prime=%0d range_error=%0b",
                             prime, range_err);
                return;
            end
            want = expected_primes.pop_front();
            checked++;
            if (want.range_err) range_errs++;
            if (prime !== want.prime || range_err !== want.range_err) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Mismatch: prime expected %0d got %0d, %s %0b got %0b",
                             want.prime, prime, "range_error expected",
                             want.range_err, range_err);
            end
        endfunction

        function int pending();
            return expected_primes.size();
        endfunction
    endclass

    logic          i_clk = 1'b0;
    logic          i_rst_n;
    logic          in_valid;
    logic          o_in_stall;
    logic [VB-1:0] start_value;
    logic          o_out_valid;
    logic          out_stall;
    logic [VB-1:0] o_next_prime;
    logic          o_range_error;

    t_prime_checker  tracker;
    bit              idle_on;
    longint unsigned cycle_count = 0;

    next_prime_search dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (o_in_stall),
        .i_start_value (start_value),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (out_stall),
        .o_next_prime  (o_next_prime),
        .o_range_error (o_range_error)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding",
                     cycle_count, tracker.pending());
            $display("Some tests failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !out_stall)
            tracker.check_result(o_next_prime, o_range_error);
    end

    // Output side: stall bursts of random length start only while idling is enabled.
    initial begin
        int stall_left;
        out_stall = 1'b0;
        stall_left = 0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
                out_stall = 1'b1;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(0, 17);
                out_stall = 1'b1;
            end else begin
                out_stall = 1'b0;
            end
        end
    end

    task automatic send_value(input logic [VB-1:0] v);
        int gap;
        if (idle_on && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 18);
            in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_valid = 1'b1;
        start_value = v;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        tracker.note_start(v);
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        while (tracker.pending() != 0) @(posedge i_clk);
    endtask

    function automatic logic [VB-1:0] random_start();
        int unsigned pick;
        logic [VB-1:0] top;
        pick = $urandom_range(0, 9);
        top = VB'(tracker.accept_max);
        unique case (pick)
            0:       return VB'($urandom_range(1, 40));
            1:       return '0;
            2:       return VB'($urandom_range(int'(top) + 1, (1 << VB) - 1));
            3:       return VB'($urandom);
            default: return VB'($urandom_range(1, int'(top)));
        endcase
    endfunction

    initial begin
        logic [VB-1:0] directed[DIRECTED_COUNT];
        logic [VB-1:0] top;
        logic [VB-1:0] mask;
        int            k;

        tracker = new();
        i_rst_n = 1'b0;
        in_valid = 1'b0;
        start_value = '0;
        idle_on = 1'b1;
        top = VB'(tracker.accept_max);
        mask = '1;

        // Zero, the smallest inputs, large prime gaps, and the edge of the range.
        directed = '{
            '0, VB'(1), VB'(2), VB'(3), VB'(4), VB'(5), VB'(8), VB'(9),
            VB'(24), VB'(113), VB'(1327), VB'(2047), VB'(2048), VB'(2730),
            VB'({VB{2'b10}} >> (VB % 2)), VB'({VB{2'b01}} >> (VB % 2)),
            top - VB'(1), top, top + VB'(1), top + VB'(2), mask - VB'(1), mask,
            VB'(1), top
        };

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        for (k = 0; k < DIRECTED_COUNT; k++) send_value(directed[k]);

        // Let the pipeline run dry once before the random traffic starts.
        in_valid = 1'b0;
        drain_results();
        @(negedge i_clk);

        for (k = 0; k < RANDOM_COUNT; k++) begin
            idle_on = (k < 60) && !(k >= 30 && k < 40);
            if (k == 45) begin
                in_valid = 1'b0;
                drain_results();
                @(negedge i_clk);
            end
            send_value(random_start());
        end
        in_valid = 1'b0;

        drain_results();
        repeat (60) @(posedge i_clk);

        $display("Checked %0d results (%0d range errors) from %0d directed",
                 tracker.checked, tracker.range_errs, DIRECTED_COUNT);
        $display("and %0d random start values; mismatches: %0d, cycles used: %0d",
                 RANDOM_COUNT, tracker.mismatches, cycle_count);
        if (tracker.mismatches == 0 && tracker.pending() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
